FILE: design/ipq_pkg.sv
// Shared definitions for the indexed priority queue update unit.
// Table sizing, command codes, entry layout and the saturating level add.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipq_pkg;

	localparam int unsigned MAX_ENTRIES = 256;
	localparam int unsigned LEVEL_BITS  = 16;
	localparam int unsigned ORDER_BITS  = 32;
	localparam int unsigned ID_BITS     = 8;
	localparam int unsigned AMOUNT_BITS = 8;
	localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
	localparam int unsigned ENTRY_W     = ORDER_BITS + LEVEL_BITS;

	typedef enum logic [1:0] {
		MODE_ARRIVE = 2'd0,
		MODE_RAISE  = 2'd1,
		MODE_LEAVE  = 2'd2,
		MODE_QUERY  = 2'd3
	} mode_t;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [LEVEL_BITS-1:0] level_t;
	typedef logic [LEVEL_BITS:0]   level_ext_t;
	typedef logic [ORDER_BITS-1:0] order_t;
	typedef logic [ID_BITS-1:0]    id_t;
	typedef logic [AMOUNT_BITS-1:0] amount_t;

	typedef struct packed {
		order_t order;
		level_t level;
	} entry_t;

	// True when the id names a slot that exists in the table.
	function automatic logic id_in_table(input id_t id);
		return 32'(id) < 32'(MAX_ENTRIES);
	endfunction

	// Add and clamp at the top of the level range.
	function automatic level_t sat_add(input level_t lvl, input amount_t amt);
		level_ext_t sum;
		sum = {1'b0, lvl} + level_ext_t'(amt);
		return sum[LEVEL_BITS] ? '1 : sum[LEVEL_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: design/ipq_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ipq_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned WIDTH = 48
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

FILE: design/indexed_priority_queue_update_unit.sv
// Top level of the indexed max-priority queue update unit.
// Depends on ipq_pkg and ipq_ram.
//
// Usage:
//   Issue a command by raising start with mode, patient_id and amount; it is
//   taken at a rising edge where start is high and busy is low.
//   arrive  - write level and arrival order for the id, mark it valid.
//   leave   - clear the id's valid bit.
//   raise   - read the entry, add amount with saturation, write it back.
//             busy while the read data returns and is written back.
//   query   - sweep the whole table through the RAM read port, one entry per
//             cycle, keeping the best level / earliest order seen so far.
//             busy for the whole sweep; the result shows on top_id /
//             empty_res with done high for one cycle right after busy
//             drops. Only query gives a result.
//   Ids at or beyond the table size are ignored; raise of an absent id is
//   dropped. Empty query reports empty_res = 1 and top_id = 0.
// Reset: arst_n clears every valid bit, the arrival counter and the control
//   state; level and order storage is not cleared and is only read for valid
//   entries, so no clearing pass is needed.
// The receiver cannot stall: done marks a single-cycle result.
`timescale 1ns / 1ps
`default_nettype none

module indexed_priority_queue_update_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] mode,
	input  wire logic [7:0] patient_id,
	input  wire logic [7:0] amount,
	output logic            done,
	output logic [7:0]      top_id,
	output logic            empty_res
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RAISE,
		ST_SCAN
	} state_t;

	localparam ipq_pkg::idx_t LAST_IDX = ipq_pkg::IDX_W'(ipq_pkg::MAX_ENTRIES - 1);

	state_t                           state_q;
	logic [ipq_pkg::MAX_ENTRIES-1:0]  valid_q;
	ipq_pkg::order_t                  arrival_q;

	// raise context
	ipq_pkg::idx_t                    raise_idx_q;
	ipq_pkg::amount_t                 amount_q;

	// scan sweep
	ipq_pkg::idx_t                    scan_ptr_q;
	logic                             issue_done_q;
	ipq_pkg::idx_t                    slot_idx_s1;
	logic                             slot_vld_s1;
	logic                             found_q;
	ipq_pkg::idx_t                    best_idx_q;
	ipq_pkg::level_t                  best_level_q;
	ipq_pkg::order_t                  best_order_q;

	// result registers
	logic                             done_q;
	logic [7:0]                       top_id_q;
	logic                             empty_res_q;

	// RAM ports
	logic                             wr_en;
	ipq_pkg::idx_t                    wr_addr;
	ipq_pkg::entry_t                  wr_entry;
	ipq_pkg::idx_t                    rd_addr;
	ipq_pkg::entry_t                  rd_entry;
	logic [ipq_pkg::ENTRY_W-1:0]      rd_data;

	logic                             accept;
	ipq_pkg::mode_t                   cmd;
	logic                             in_table;
	ipq_pkg::idx_t                    id_idx;
	logic                             take;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cmd       = ipq_pkg::mode_t'(mode);
	assign in_table  = ipq_pkg::id_in_table(patient_id);
	assign id_idx    = ipq_pkg::IDX_W'(patient_id);
	assign rd_entry  = ipq_pkg::entry_t'(rd_data);

	assign done      = done_q;
	assign top_id    = top_id_q;
	assign empty_res = empty_res_q;

	// Read address: the raise target or slot 0 on accept, the sweep pointer
	// while scanning.
	always_comb begin
		if (state_q == ST_SCAN) begin
			rd_addr = scan_ptr_q;
		end else if (cmd == ipq_pkg::MODE_QUERY) begin
			rd_addr = '0;
		end else begin
			rd_addr = id_idx;
		end
	end

	// Write port: arrive writes a fresh entry at once; raise writes back the
	// modified level in the cycle after its read, keeping the stored order.
	always_comb begin
		if (state_q == ST_RAISE) begin
			wr_en          = 1'b1;
			wr_addr        = raise_idx_q;
			wr_entry.order = rd_entry.order;
			wr_entry.level = ipq_pkg::sat_add(rd_entry.level, amount_q);
		end else begin
			wr_en          = accept && (cmd == ipq_pkg::MODE_ARRIVE) && in_table;
			wr_addr        = id_idx;
			wr_entry.order = arrival_q;
			wr_entry.level = ipq_pkg::sat_add('0, amount);
		end
	end

	// Running best: higher level wins, then lower order; equal on both keeps
	// the earlier (lower) index because the sweep runs upward.
	always_comb begin
		take = (state_q == ST_SCAN) && slot_vld_s1 &&
		       (!found_q ||
		        (rd_entry.level > best_level_q) ||
		        ((rd_entry.level == best_level_q) && (rd_entry.order < best_order_q)));
	end

	ipq_ram #(
		.DEPTH (ipq_pkg::MAX_ENTRIES),
		.WIDTH (ipq_pkg::ENTRY_W)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			arrival_q    <= '0;
			raise_idx_q  <= '0;
			amount_q     <= '0;
			scan_ptr_q   <= '0;
			issue_done_q <= 1'b0;
			slot_idx_s1  <= '0;
			slot_vld_s1  <= 1'b0;
			found_q      <= 1'b0;
			best_idx_q   <= '0;
			best_level_q <= '0;
			best_order_q <= '0;
			done_q       <= 1'b0;
			top_id_q     <= '0;
			empty_res_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd)
							ipq_pkg::MODE_ARRIVE: begin
								if (in_table) begin
									valid_q[id_idx] <= 1'b1;
									arrival_q       <= arrival_q + 1'b1;
								end
							end
							ipq_pkg::MODE_RAISE: begin
								// drop raise of an absent id
								if (in_table && valid_q[id_idx]) begin
									raise_idx_q <= id_idx;
									amount_q    <= amount;
									state_q     <= ST_RAISE;
								end
							end
							ipq_pkg::MODE_LEAVE: begin
								if (in_table) begin
									valid_q[id_idx] <= 1'b0;
								end
							end
							ipq_pkg::MODE_QUERY: begin
								// slot 0 is read this cycle
								scan_ptr_q   <= ipq_pkg::IDX_W'(1);
								issue_done_q <= 1'b0;
								slot_idx_s1  <= '0;
								slot_vld_s1  <= valid_q[ipq_pkg::IDX_W'(0)];
								found_q      <= 1'b0;
								state_q      <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RAISE: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					// advance the read pointer until the last slot is issued
					if (!issue_done_q) begin
						slot_idx_s1  <= scan_ptr_q;
						slot_vld_s1  <= valid_q[scan_ptr_q];
						scan_ptr_q   <= scan_ptr_q + 1'b1;
						issue_done_q <= (scan_ptr_q == LAST_IDX);
					end
					if (take) begin
						found_q      <= 1'b1;
						best_idx_q   <= slot_idx_s1;
						best_level_q <= rd_entry.level;
						best_order_q <= rd_entry.order;
					end
					// last slot compared: publish the winner
					if (issue_done_q) begin
						done_q      <= 1'b1;
						empty_res_q <= !(found_q || take);
						if (take) begin
							top_id_q <= 8'(slot_idx_s1);
						end else if (found_q) begin
							top_id_q <= 8'(best_idx_q);
						end else begin
							top_id_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: design/ipq_checker.sv
// Port-level checks for the indexed priority queue update unit, bound to it.
// Depends on ipq_pkg and indexed_priority_queue_update_unit.
`timescale 1ns / 1ps
`default_nettype none

module ipq_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [1:0] mode,
	input wire logic       done,
	input wire logic [7:0] top_id,
	input wire logic       empty_res
);

	logic q_accept;
	logic other_accept;

	assign q_accept     = start && !busy && (mode == ipq_pkg::MODE_QUERY);
	assign other_accept = start && !busy && (mode != ipq_pkg::MODE_QUERY);

	// a query holds the unit busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_accept |=> busy)
		else $error("query accepted but busy not raised");

	// results appear only after a busy sweep
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result strobe without a preceding sweep");

	// non-query items give no result
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		other_accept |=> !done)
		else $error("result after a non-query item");

	// empty query reports id zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && empty_res) |-> (top_id == 8'd0))
		else $error("empty result with nonzero id");

endmodule

bind indexed_priority_queue_update_unit ipq_checker u_ipq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.mode      (mode),
	.done      (done),
	.top_id    (top_id),
	.empty_res (empty_res)
);

`default_nettype wire
